@@ rtl/core/maic_pkg.sv @@
// ----------------------------------------------------------------------------
// maic_pkg
// Types, character codes and the IUPAC fold table for the majority allele
// IUPAC caller.
// ----------------------------------------------------------------------------
package maic_pkg;

  localparam int DEPTH_W = 32;
  localparam int MIN_W   = 31;
  localparam int CHAR_W  = 8;
  localparam int TIE_W   = 5;

  localparam logic [CHAR_W-1:0] CHAR_N = 8'h4E;  // 'N'

  typedef logic [CHAR_W-1:0] char_t;

  typedef struct packed {
    logic signed [DEPTH_W-1:0] depth;
    char_t                     base_char;
    logic                      last_allele;
  } in_item_t;

  typedef struct packed {
    char_t            call_char;
    logic             no_call;
    logic [TIE_W-1:0] tied_count;
  } out_item_t;

  typedef struct packed {
    logic signed [DEPTH_W-1:0] best_depth;
    char_t                     running_call;
    logic [TIE_W-1:0]          tie_count;
  } call_state_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] idx;
  } nuc_t;

  // rows/cols: A C G T
  localparam char_t IUPAC_TAB [4][4] = '{
    '{8'h41, 8'h4D, 8'h52, 8'h57},  // A M R W
    '{8'h4D, 8'h43, 8'h53, 8'h59},  // M C S Y
    '{8'h52, 8'h53, 8'h47, 8'h4B},  // R S G K
    '{8'h57, 8'h59, 8'h4B, 8'h54}   // W Y K T
  };

  function automatic nuc_t nuc_index(input char_t c);
    nuc_t n;
    n.valid = 1'b1;
    n.idx   = 2'd0;
    case (c)
      8'h41, 8'h61: n.idx = 2'd0;
      8'h43, 8'h63: n.idx = 2'd1;
      8'h47, 8'h67: n.idx = 2'd2;
      8'h54, 8'h74: n.idx = 2'd3;
      default:      n.valid = 1'b0;
    endcase
    return n;
  endfunction

  function automatic char_t fold_iupac(input char_t x, input char_t y);
    nuc_t i;
    nuc_t j;
    i = nuc_index(x);
    j = nuc_index(y);
    if (i.valid && j.valid) begin
      return IUPAC_TAB[i.idx][j.idx];
    end
    return CHAR_N;
  endfunction

endpackage

@@ rtl/core/maic_stream_if.sv @@
// ----------------------------------------------------------------------------
// maic_stream_if
// Valid/ready request channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface maic_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/maic_fold.sv @@
// ----------------------------------------------------------------------------
// maic_fold
// Per-allele update: depth compare against the running best, restart or
// IUPAC fold of the call, saturating tie count, and the position result.
// ----------------------------------------------------------------------------
module maic_fold #(
  parameter int MAX_ALLELES = 16
) (
  input  maic_pkg::call_state_t         cur,
  input  logic [maic_pkg::MIN_W-1:0]    min_depth,
  input  maic_pkg::in_item_t            item,
  output maic_pkg::call_state_t         nxt,
  output maic_pkg::out_item_t           result
);
  import maic_pkg::*;

  localparam int CAP_INT = (MAX_ALLELES < 31) ? MAX_ALLELES : 31;
  localparam logic [TIE_W-1:0] TIE_CAP = TIE_W'(CAP_INT);

  logic signed [DEPTH_W-1:0] best_eff;
  logic                      empty;
  logic                      gt;
  logic                      eq;

  always_comb begin
    empty    = (cur.tie_count == '0);
    // with nothing called yet the threshold is the live min_depth
    best_eff = empty ? $signed({1'b0, min_depth}) : cur.best_depth;
    gt       = (item.depth > best_eff);
    eq       = (item.depth == best_eff);

    nxt = cur;
    if (gt || (eq && empty)) begin
      nxt.best_depth   = item.depth;
      nxt.running_call = item.base_char;
      nxt.tie_count    = TIE_W'(1);
    end else if (eq) begin
      nxt.running_call = fold_iupac(cur.running_call, item.base_char);
      if (cur.tie_count < TIE_CAP) begin
        nxt.tie_count = cur.tie_count + TIE_W'(1);
      end
    end

    if (nxt.tie_count == '0) begin
      result.call_char  = CHAR_N;
      result.no_call    = 1'b1;
      result.tied_count = '0;
    end else begin
      result.call_char  = nxt.running_call;
      result.no_call    = 1'b0;
      result.tied_count = nxt.tie_count;
    end
  end

endmodule

@@ rtl/core/majority_allele_iupac_call.sv @@
// ----------------------------------------------------------------------------
// majority_allele_iupac_call
// Majority consensus base call per genome position with IUPAC folding of
// alleles that tie at the top depth.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                          | handshake
//  in_if    | in  | depth, base_char, last_allele    | valid/ready
//  out_if   | out | call_char, no_call, tied_count   | valid/ready
//  cfg_*    | in  | min_depth (31 b)                 | write enable only
//
//  One allele per cycle unless a last allele waits on a stalled result;
//  a taken last allele passes the input register, then the result register.
//  The combinational compare and table fold bound the rate.
//  Reset clears the call state and sets min_depth to 1.
//  A stalled result holds only alleles marked last; others keep flowing.
// ----------------------------------------------------------------------------
module majority_allele_iupac_call #(
  parameter int MAX_ALLELES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  maic_stream_if.sink                in_if,
  maic_stream_if.source              out_if,
  input  logic                       cfg_we,
  input  logic [maic_pkg::MIN_W-1:0] cfg_wdata
);
  import maic_pkg::*;

  logic [MIN_W-1:0] min_depth_r;
  logic             s1_valid_r;
  in_item_t         s1_item_r;
  call_state_t      state_r;
  call_state_t      state_nxt;
  out_item_t        result;
  logic             out_valid_r;
  out_item_t        out_data_r;
  logic             s1_adv;

  maic_fold #(.MAX_ALLELES(MAX_ALLELES)) u_fold (
    .cur       (state_r),
    .min_depth (min_depth_r),
    .item      (s1_item_r),
    .nxt       (state_nxt),
    .result    (result)
  );

  assign s1_adv = s1_valid_r &&
                  (!s1_item_r.last_allele || !out_valid_r || out_if.ready);
  assign in_if.ready  = !s1_valid_r || s1_adv;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_depth_r <= MIN_W'(1);
    end else if (cfg_we) begin
      min_depth_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_item_r <= in_if.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.best_depth   <= '0;
      state_r.running_call <= CHAR_N;
      state_r.tie_count    <= '0;
    end else if (s1_adv) begin
      state_r.best_depth   <= state_nxt.best_depth;
      state_r.running_call <= state_nxt.running_call;
      state_r.tie_count    <= s1_item_r.last_allele ? '0 : state_nxt.tie_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_item_r.last_allele) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_item_r.last_allele) begin
      out_data_r <= result;
    end
  end

endmodule

@@ rtl/core/maic_checker.sv @@
// ----------------------------------------------------------------------------
// maic_checker
// Port-level checks on the result channel of the majority allele caller.
// ----------------------------------------------------------------------------
module maic_checker #(
  parameter int MAX_ALLELES = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [maic_pkg::CHAR_W-1:0]   call_char,
  input logic                          no_call,
  input logic [maic_pkg::TIE_W-1:0]    tied_count
);
  import maic_pkg::*;

  localparam int CAP_INT = (MAX_ALLELES < 31) ? MAX_ALLELES : 31;
  localparam logic [TIE_W-1:0] TIE_CAP = TIE_W'(CAP_INT);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(call_char))
    else $error("result dropped or changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_no_call: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && no_call |-> call_char == CHAR_N && tied_count == '0)
    else $error("no-call result not N with zero ties");

  a_ties: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !no_call |-> tied_count != '0 && tied_count <= TIE_CAP)
    else $error("tie count out of range");

endmodule

bind majority_allele_iupac_call maic_checker #(.MAX_ALLELES(MAX_ALLELES)) u_maic_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .call_char  (out_if.data.call_char),
  .no_call    (out_if.data.no_call),
  .tied_count (out_if.data.tied_count)
);
